// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Uses the i_clk and i_rst_n ports of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/hfpd_pkg.sv =====
// Types and constant tables for the HTTP first-packet detector.
// No dependencies.
package hfpd_pkg;

    localparam int NUM_METHODS    = 26;
    localparam int METHOD_MAX_LEN = 12;
    localparam int STATUS_LEN     = 8;
    localparam int WINDOW         = 9;

    localparam logic [3:0] POS_MAX = 4'd15;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    // words are right-justified: last char in bits [7:0]
    localparam logic [8*METHOD_MAX_LEN-1:0] METHOD_WORDS [NUM_METHODS] = '{
        "DELETE ", "GET ", "HEAD ", "POST ", "PUT ", "CONNECT ", "OPTIONS ",
        "TRACE ", "COPY ", "LOCK ", "MKCOL ", "MOVE ", "PROPFIND ",
        "PROPPATCH ", "SEARCH ", "UNLOCK ", "REPORT ", "MKACTIVITY ",
        "CHECKOUT ", "MERGE ", "MSEARCH ", "NOTIFY ", "SUBSCRIBE ",
        "UNSUBSCRIBE ", "PATCH ", "PURGE "
    };

    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd7, 4'd4, 4'd5, 4'd5, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5, 4'd5, 4'd6,
        4'd5, 4'd9, 4'd10, 4'd7, 4'd7, 4'd7, 4'd11, 4'd9, 4'd6, 4'd8, 4'd7,
        4'd10, 4'd12, 4'd6, 4'd6
    };

    localparam logic [8*STATUS_LEN-1:0] STATUS_HEAD = "HTTP/1.0";

    typedef struct packed {
        logic [7:0] data;
        logic       client;
        logic       last;
    } t_item;

    // char p of method m; valid only for p < METHOD_LEN[m]
    function automatic logic [7:0] method_char(input logic [4:0] m, input logic [3:0] p);
        logic [3:0] idx;
        logic [6:0] sh;
        idx = METHOD_LEN[m] - p - 4'd1;
        sh  = {idx, 3'b000};
        return METHOD_WORDS[m][sh +: 8];
    endfunction

    // char p of the status head; p < STATUS_LEN
    function automatic logic [7:0] status_char(input logic [2:0] p);
        logic [2:0] idx;
        logic [5:0] sh;
        idx = 3'd7 - p;
        sh  = {idx, 3'b000};
        return STATUS_HEAD[sh +: 8];
    endfunction

endpackage

// ===== hw/rtl/hfpd_match.sv =====
// Per-packet signature state and verdict logic of the HTTP detector.
// Depends on hfpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hfpd_match import hfpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_item i_item,
    output logic  o_http
);

    logic [3:0]             r_pos, n_pos, v_pos;
    logic [NUM_METHODS-1:0] r_alive, n_alive, v_alive;
    logic                   r_matched, n_matched, v_matched;
    logic [1:0]             r_status, n_status, v_status;
    logic                   r_line_end, n_line_end, v_line_end;
    logic [7:0]             r_recent [WINDOW];
    logic                   w_version;

    always_comb begin
        w_version = (r_recent[1] == CHAR_ZERO) || (r_recent[1] == CHAR_ONE);
        for (int k = 0; k < 7; k++) begin
            if (r_recent[8-k] != status_char(3'(k))) begin
                w_version = 1'b0;
            end
        end
    end

    always_comb begin
        v_pos      = r_pos;
        v_alive    = r_alive;
        v_matched  = r_matched;
        v_status   = r_status;
        v_line_end = r_line_end;

        if (r_pos < 4'(METHOD_MAX_LEN)) begin
            for (int m = 0; m < NUM_METHODS; m++) begin
                if (r_alive[m] && (r_pos < METHOD_LEN[m])) begin
                    if (i_item.data != method_char(5'(m), r_pos)) begin
                        v_alive[m] = 1'b0;
                    end else if (r_pos == METHOD_LEN[m] - 4'd1) begin
                        v_matched = 1'b1;
                    end
                end
            end
        end

        if (r_pos < 4'd7) begin
            if (i_item.data != status_char(r_pos[2:0])) begin
                v_status = 2'b00;
            end
        end else if (r_pos == 4'd7) begin
            if (i_item.data != CHAR_ZERO) begin
                v_status[0] = 1'b0;
            end
            if (i_item.data != CHAR_ONE) begin
                v_status[1] = 1'b0;
            end
        end

        if ((i_item.data == CHAR_LF) && (r_pos >= 4'd9) && (r_recent[0] == CHAR_CR)
                && w_version) begin
            v_line_end = 1'b1;
        end

        if (r_pos < POS_MAX) begin
            v_pos = r_pos + 4'd1;
        end
    end

    assign o_http = i_item.client ? (v_matched && v_line_end)
                                  : ((v_pos >= 4'd8) && (v_status != 2'b00));

    always_comb begin
        if (i_item.last) begin
            n_pos      = '0;
            n_alive    = '1;
            n_matched  = 1'b0;
            n_status   = 2'b11;
            n_line_end = 1'b0;
        end else begin
            n_pos      = v_pos;
            n_alive    = v_alive;
            n_matched  = v_matched;
            n_status   = v_status;
            n_line_end = v_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_alive    <= '1;
            r_matched  <= 1'b0;
            r_status   <= 2'b11;
            r_line_end <= 1'b0;
        end else if (i_en) begin
            r_pos      <= n_pos;
            r_alive    <= n_alive;
            r_matched  <= n_matched;
            r_status   <= n_status;
            r_line_end <= n_line_end;
        end
    end

    // window bytes are only read once nine bytes of the packet are in
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_recent[0] <= i_item.data;
            for (int k = 1; k < WINDOW; k++) begin
                r_recent[k] <= r_recent[k-1];
            end
        end
    end

    `ASSERT_NEXT(a_clear_after_last, i_en && i_item.last, r_pos == 4'd0,
        "position not cleared after last item")
    `ASSERT_IMPL(a_matched_pos, r_matched, r_pos >= 4'd4,
        "method match before four items")
    `ASSERT_IMPL(a_line_end_pos, r_line_end, r_pos >= 4'd10,
        "line end found before ten items")
    `ASSERT_IMPL(a_status_idle, r_pos == 4'd0, (r_status == 2'b11) && !r_matched,
        "status or method state set at packet start")

endmodule

// ===== hw/rtl/http_first_packet_detector.sv =====
// Top level of the HTTP first-packet detector: stream ports, input and
// result registers. Depends on hfpd_pkg and hfpd_match.
//
//  port group   dir  item contents
//  s_axis_*     in   one payload byte, direction, end of packet
//  m_axis_*     out  one verdict per packet
//
// One byte accepted per cycle unless the input stalls. A verdict is presented
// after its packet's last byte passes input register, then result register.
// Reset (synchronous, active low) clears the packet state, but not the byte window.
// The input stalls only when a last byte sits in the input register while the
// result register holds a verdict that is not taken.
module http_first_packet_detector import hfpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] from_client
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_http, [7:1] zero
);

    logic  r_in_valid, n_in_valid;
    t_item r_in;
    logic  r_out_valid, n_out_valid;
    logic  r_out_http;
    logic  w_go;
    logic  w_http;

    assign w_go          = r_in_valid && (!r_in.last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_go;

    assign n_in_valid  = s_axis_tready ? s_axis_tvalid : r_in_valid;
    assign n_out_valid = (w_go && r_in.last) ? 1'b1
                                             : (m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.data   <= s_axis_tdata;
            r_in.client <= s_axis_tuser;
            r_in.last   <= s_axis_tlast;
        end
        if (w_go && r_in.last) begin
            r_out_http <= w_http;
        end
    end

    hfpd_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_go),
        .i_item  (r_in),
        .o_http  (w_http)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_http};

endmodule
